FILE: hdl/min_weight_supplier_search_macros.svh
// Assertion macros for the minimum-weight supplier search block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MIN_WEIGHT_SUPPLIER_SEARCH_MACROS_SVH
`define MIN_WEIGHT_SUPPLIER_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MWSS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define MWSS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mwss_pkg.sv
// Shared types and constants of the minimum-weight supplier search.
// No dependencies; imported by every module of the block.
package mwss_pkg;

    localparam int unsigned CHOICE_W = 5;
    localparam int unsigned TOTAL_W  = 21;
    localparam logic [TOTAL_W-1:0] NO_SOLUTION_WEIGHT = 21'd999999;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PART_COUNT     = 2'd0;
    localparam logic [1:0] REG_SUPPLIER_COUNT = 2'd1;
    localparam logic [1:0] REG_PRICE_LIMIT    = 2'd2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_UNDO,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [4:0]  part_count;
        logic [4:0]  supplier_count;
        logic [20:0] price_limit;
    } t_cfg;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  part_index;
        logic [3:0]  supplier_index;
        logic [15:0] part_weight;
        logic [15:0] part_price;
    } t_in_item;

    // One table entry: price and weight of a part from one supplier
    typedef struct packed {
        logic [15:0] price;
        logic [15:0] weight;
    } t_entry;

    typedef struct packed {
        logic        valid;
        logic [3:0]  out_part;
        logic [4:0]  chosen_supplier;
        logic [19:0] best_weight;
        logic        found;
        logic        last;
    } t_result;

endpackage

FILE: hdl/mwss_table.sv
// Weight and price table: single-port write, registered read.
// Depends on mwss_pkg for the entry type.
module mwss_table #(
    parameter int unsigned ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  mwss_pkg::t_entry  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output mwss_pkg::t_entry  o_rdata
);
    import mwss_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mwss_search.sv
// Search sequencer: table loads, depth-first branch and bound with a level
// stack, and result emission. Depends on mwss_pkg; drives mwss_table.
module mwss_search #(
    parameter int unsigned MAX_PARTS     = 16,
    parameter int unsigned MAX_SUPPLIERS = 16,
    parameter int unsigned PW            = 4,
    parameter int unsigned SW            = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwss_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mwss_pkg::t_in_item i_in,
    output logic               o_tbl_we,
    output logic [PW+SW-1:0]   o_tbl_waddr,
    output mwss_pkg::t_entry   o_tbl_wdata,
    output logic [PW+SW-1:0]   o_tbl_raddr,
    input  mwss_pkg::t_entry   i_tbl_rdata,
    input  logic               i_res_room,
    output mwss_pkg::t_result  o_res
);
    import mwss_pkg::*;

    localparam int unsigned LW = $clog2(MAX_PARTS + 1);

    t_state r_state, n_state;

    logic [LW-1:0]       r_n, n_n;
    logic [4:0]          r_m, n_m;
    logic [LW-1:0]       r_level, n_level;
    logic [5:0]          r_j, n_j;
    logic [TOTAL_W-1:0]  r_rw, n_rw;
    logic [TOTAL_W-1:0]  r_rp, n_rp;
    logic [TOTAL_W-1:0]  r_best, n_best;
    logic                r_found, n_found;
    logic [LW-1:0]       r_k, n_k;
    logic [CHOICE_W-1:0] r_stack [MAX_PARTS];
    logic [CHOICE_W-1:0] n_stack [MAX_PARTS];
    logic [CHOICE_W-1:0] r_bestc [MAX_PARTS];
    logic [CHOICE_W-1:0] n_bestc [MAX_PARTS];

    logic                in_acc;
    logic                load_ok;
    logic                leaf;
    logic                j_over;
    logic                take;
    logic                push;
    logic [LW-1:0]       lvl_m1;
    logic [PW-1:0]       lvl_idx;
    logic [PW-1:0]       lvl_m1_idx;
    logic [CHOICE_W-1:0] back_choice;
    logic [PW+SW-1:0]    fwd_addr;
    logic [PW+SW-1:0]    back_addr;
    logic [TOTAL_W:0]    price_sum;
    logic [TOTAL_W:0]    weight_sum;
    logic [LW-1:0]       n_start;
    logic [4:0]          m_start;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Loads beyond the configured table size are dropped
    assign load_ok = ({3'b0, i_in.part_index} < 7'(MAX_PARTS))
                  && ({3'b0, i_in.supplier_index} < 7'(MAX_SUPPLIERS));
    assign o_tbl_we    = in_acc && (i_in.operation == OP_LOAD) && load_ok;
    assign o_tbl_waddr = {PW'(i_in.part_index), SW'(i_in.supplier_index)};
    assign o_tbl_wdata = '{price: i_in.part_price, weight: i_in.part_weight};

    // Clamp the configured counts
    always_comb begin
        if (i_cfg.part_count == 5'd0) begin
            n_start = LW'(1);
        end else if ({2'b0, i_cfg.part_count} > 7'(MAX_PARTS)) begin
            n_start = LW'(MAX_PARTS);
        end else begin
            n_start = LW'(i_cfg.part_count);
        end
        if ({2'b0, i_cfg.supplier_count} > 7'(MAX_SUPPLIERS)) begin
            m_start = 5'(MAX_SUPPLIERS);
        end else begin
            m_start = i_cfg.supplier_count;
        end
    end

    // Level decode and table addresses
    assign leaf        = (r_level >= r_n);
    assign j_over      = (r_j > {1'b0, r_m});
    assign lvl_m1      = r_level - LW'(1);
    assign lvl_idx     = r_level[PW-1:0];
    assign lvl_m1_idx  = lvl_m1[PW-1:0];
    assign back_choice = r_stack[lvl_m1_idx] - CHOICE_W'(1);
    assign fwd_addr    = {lvl_idx, SW'(r_j - 6'd1)};
    assign back_addr   = {lvl_m1_idx, SW'(back_choice)};
    assign o_tbl_raddr = (leaf || j_over) ? back_addr : fwd_addr;

    // Bound checks on the candidate just read
    assign price_sum  = {1'b0, r_rp} + (TOTAL_W+1)'(i_tbl_rdata.price);
    assign weight_sum = {1'b0, r_rw} + (TOTAL_W+1)'(i_tbl_rdata.weight);
    assign take       = (price_sum <= {1'b0, i_cfg.price_limit})
                     && (weight_sum < {1'b0, r_best});

    assign push = (r_state == S_EMIT) && i_res_room;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.operation == OP_START)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (leaf) begin
                    n_state = S_UNDO;
                end else if (j_over) begin
                    n_state = (r_level == '0) ? S_EMIT : S_UNDO;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: n_state = S_SCAN;
            S_UNDO: n_state = S_SCAN;
            S_EMIT: begin
                if (push && (r_k == r_n - LW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        n_n     = r_n;
        n_m     = r_m;
        n_level = r_level;
        n_j     = r_j;
        n_rw    = r_rw;
        n_rp    = r_rp;
        n_best  = r_best;
        n_found = r_found;
        n_k     = r_k;
        n_stack = r_stack;
        n_bestc = r_bestc;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.operation == OP_START)) begin
                    n_n     = n_start;
                    n_m     = m_start;
                    n_level = '0;
                    n_j     = 6'd1;
                    n_rw    = '0;
                    n_rp    = '0;
                    n_best  = NO_SOLUTION_WEIGHT;
                    n_found = 1'b0;
                    for (int i = 0; i < MAX_PARTS; i++) begin
                        n_stack[i] = '0;
                        n_bestc[i] = '0;
                    end
                end
            end
            S_SCAN: begin
                if (leaf) begin
                    // Complete assignment: keep it when strictly lighter
                    if (r_rw < r_best) begin
                        n_best  = r_rw;
                        n_bestc = r_stack;
                        n_found = 1'b1;
                    end
                    n_level = lvl_m1;
                end else if (j_over) begin
                    // No supplier left at this level: clear it and back up
                    n_stack[lvl_idx] = '0;
                    n_k = '0;
                    if (r_level != '0) begin
                        n_level = lvl_m1;
                    end
                end
            end
            S_EVAL: begin
                if (take) begin
                    n_stack[lvl_idx] = r_j[CHOICE_W-1:0];
                    n_rp    = price_sum[TOTAL_W-1:0];
                    n_rw    = weight_sum[TOTAL_W-1:0];
                    n_level = r_level + LW'(1);
                    n_j     = 6'd1;
                end else begin
                    n_j = r_j + 6'd1;
                end
            end
            S_UNDO: begin
                // Remove the choice made at the level we returned to
                n_rp = r_rp - TOTAL_W'(i_tbl_rdata.price);
                n_rw = r_rw - TOTAL_W'(i_tbl_rdata.weight);
                n_j  = {1'b0, r_stack[lvl_idx]} + 6'd1;
            end
            S_EMIT: begin
                if (push) begin
                    n_k = r_k + LW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_found <= 1'b0;
            r_best  <= NO_SOLUTION_WEIGHT;
            r_level <= '0;
            r_rw    <= '0;
            r_rp    <= '0;
            for (int i = 0; i < MAX_PARTS; i++) begin
                r_stack[i] <= '0;
                r_bestc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_found <= n_found;
            r_best  <= n_best;
            r_level <= n_level;
            r_rw    <= n_rw;
            r_rp    <= n_rp;
            r_stack <= n_stack;
            r_bestc <= n_bestc;
        end
    end

    // Search bounds and candidate counter
    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_m <= n_m;
        r_j <= n_j;
    end

    // Result for part r_k
    always_comb begin
        o_res.valid           = (r_state == S_EMIT);
        o_res.out_part        = 4'(r_k);
        o_res.chosen_supplier = r_found ? r_bestc[r_k[PW-1:0]] : '0;
        o_res.best_weight     = r_best[19:0];
        o_res.found           = r_found;
        o_res.last            = (r_k == r_n - LW'(1));
    end

endmodule

FILE: hdl/min_weight_supplier_search.sv
// Minimum-weight supplier search, top level.
// Slave stream: tuser = operation; tdata (40 bits) = part_index, supplier_index,
// part_weight, part_price from bit 0 up. A load writes one weight/price entry
// and a start runs the branch-and-bound search.
// Master stream: one item per part after a start; tdata (32 bits) = out_part,
// chosen_supplier, best_weight from bit 0 up, tuser = found, tlast on the
// final part.
// Search steps of a start: a scan and an evaluate state for every candidate
// supplier examined, a scan state for each leaf or exhausted level and an undo
// state for every step back up a level. The results pass from the emit state
// through the output register, one per cycle while m_axis_tready is high. The
// search cost is set by the single read port of the table memory, which is registered.
// The search handles one item at a time; s_axis_tready is low from the start
// item until the last result has been handed to the output register.
// The output register holds a result while m_axis_tready is low; the search
// waits for it, and the next item is taken while the last result still waits.
// Reset (i_rst_n low, synchronous) empties the output register and loads
// part_count = 1, supplier_count = 1, price_limit = 0. Table contents are not
// cleared; entries must be loaded before a search reads them.
// APB registers: part_count at 0x0, supplier_count at 0x4, price_limit at 0x8.
`include "min_weight_supplier_search_macros.svh"

module min_weight_supplier_search #(
    parameter int unsigned MAX_PARTS     = 16,
    parameter int unsigned MAX_SUPPLIERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // part_index, supplier_index, part_weight, part_price
    input  logic [0:0]  s_axis_tuser,  // operation
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_part, chosen_supplier, best_weight, zero pad
    output logic [0:0]  m_axis_tuser,  // found
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwss_pkg::*;

    localparam int unsigned PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int unsigned SW = (MAX_SUPPLIERS > 1) ? $clog2(MAX_SUPPLIERS) : 1;
    localparam int unsigned AW = PW + SW;

    t_cfg     r_cfg;
    t_in_item in_item;
    t_result  w_res;
    t_result  r_out;
    logic     r_out_valid;
    logic     w_room;
    logic     cfg_wr;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_raddr;
    t_entry        tbl_wdata;
    t_entry        tbl_rdata;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.part_count     <= 5'd1;
            r_cfg.supplier_count <= 5'd1;
            r_cfg.price_limit    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PART_COUNT:     r_cfg.part_count     <= pwdata[4:0];
                REG_SUPPLIER_COUNT: r_cfg.supplier_count <= pwdata[4:0];
                REG_PRICE_LIMIT:    r_cfg.price_limit    <= pwdata[20:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PART_COUNT:     prdata = {27'b0, r_cfg.part_count};
            REG_SUPPLIER_COUNT: prdata = {27'b0, r_cfg.supplier_count};
            REG_PRICE_LIMIT:    prdata = {11'b0, r_cfg.price_limit};
            default:            prdata = '0;
        endcase
    end

    // Unpack the input item
    assign in_item.operation      = t_op'(s_axis_tuser[0]);
    assign in_item.part_index     = s_axis_tdata[3:0];
    assign in_item.supplier_index = s_axis_tdata[7:4];
    assign in_item.part_weight    = s_axis_tdata[23:8];
    assign in_item.part_price     = s_axis_tdata[39:24];

    mwss_table #(
        .ADDR_W (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    mwss_search #(
        .MAX_PARTS     (MAX_PARTS),
        .MAX_SUPPLIERS (MAX_SUPPLIERS),
        .PW            (PW),
        .SW            (SW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in        (in_item),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .i_res_room  (w_room),
        .o_res       (w_res)
    );

    // Output register: takes a new result when empty or being drained
    assign w_room = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_room) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_room && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out.best_weight, r_out.chosen_supplier, r_out.out_part};
    assign m_axis_tuser  = r_out.found;
    assign m_axis_tlast  = r_out.last;

    // Checks
    `MWSS_CHECK(a_no_solution_fields, r_out_valid && !r_out.found, (r_out.chosen_supplier == 5'd0) && (r_out.best_weight == NO_SOLUTION_WEIGHT[19:0]), "result without solution carries a choice or weight")
    `MWSS_CHECK(a_found_has_choice, r_out_valid && r_out.found, (r_out.chosen_supplier != 5'd0) && (r_out.best_weight != NO_SOLUTION_WEIGHT[19:0]), "found result lacks a supplier or weight")
    `MWSS_CHECK(a_busy_while_emitting, w_res.valid, !s_axis_tready, "input taken while results are pending")
    `MWSS_CHECK_NEXT(a_ready_after_last, w_res.valid && w_room && w_res.last, s_axis_tready, "block not ready after its last result")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the minimum-weight supplier search block.
// Depends on mwss_pkg and min_weight_supplier_search; predicts results with its own search.
module tb_top;
    import mwss_pkg::*;

    localparam int unsigned PART_SLOTS  = 16;
    localparam int unsigned SUPP_SLOTS  = 16;
    localparam int unsigned ITEM_TARGET = 330;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [20:0] LIMIT_MAX   = 21'h1FFFFF;

    // One result item as it leaves the block
    typedef struct packed {
        logic [3:0]  part;
        logic [4:0]  supplier;
        logic [19:0] weight;
        logic        found;
        logic        last;
    } t_outcome;

    // Scoreboard: mirrors tables and registers, queues expected results
    class search_scoreboard;
        logic [15:0] weight_tab [PART_SLOTS][SUPP_SLOTS];
        logic [15:0] price_tab  [PART_SLOTS][SUPP_SLOTS];
        logic [4:0]  parts_reg;
        logic [4:0]  suppliers_reg;
        logic [20:0] limit_reg;
        t_outcome    expected [$];
        int          errors;

        function new();
            parts_reg     = 5'd1;
            suppliers_reg = 5'd1;
            limit_reg     = '0;
            errors        = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_PART_COUNT:     parts_reg     = value[4:0];
                REG_SUPPLIER_COUNT: suppliers_reg = value[4:0];
                REG_PRICE_LIMIT:    limit_reg     = value[20:0];
                default: ;
            endcase
        endfunction

        // Zero parts act as one; counts above the table size are clipped
        function int unsigned active_parts();
            if (parts_reg == 0)
                return 1;
            if (parts_reg > PART_SLOTS)
                return PART_SLOTS;
            return parts_reg;
        endfunction

        function int unsigned active_suppliers();
            if (suppliers_reg > SUPP_SLOTS)
                return SUPP_SLOTS;
            return suppliers_reg;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Depth-first branch and bound, one result per part queued at the end
        function void solve_min_weight();
            int unsigned n, m, lvl, rw, rp, best, j, k;
            bit          found, descend;
            bit [4:0]    pick [PART_SLOTS];
            bit [4:0]    keep [PART_SLOTS];
            t_outcome    res;
            n     = active_parts();
            m     = active_suppliers();
            best  = NO_SOLUTION_WEIGHT;
            rw    = 0;
            rp    = 0;
            lvl   = 0;
            found = 0;
            for (k = 0; k < PART_SLOTS; k++) begin
                pick[k] = '0;
                keep[k] = '0;
            end
            while (1) begin
                descend = 0;
                if (lvl >= n) begin
                    // every part has a supplier: keep only a strictly lighter machine
                    if (rw < best) begin
                        best = rw;
                        for (k = 0; k < n; k++)
                            keep[k] = pick[k];
                        found = 1;
                    end
                end else begin
                    for (j = pick[lvl] + 1; j <= m; j++) begin
                        if (rp + price_tab[lvl][j-1] <= limit_reg &&
                            rw + weight_tab[lvl][j-1] < best) begin
                            pick[lvl] = 5'(j);
                            rp += price_tab[lvl][j-1];
                            rw += weight_tab[lvl][j-1];
                            lvl++;
                            if (lvl < n)
                                pick[lvl] = '0;
                            descend = 1;
                            break;
                        end
                    end
                    if (!descend)
                        pick[lvl] = '0;
                end
                if (!descend) begin
                    // step back and undo the choice of the level above
                    if (lvl == 0)
                        break;
                    lvl--;
                    rp -= price_tab[lvl][pick[lvl]-1];
                    rw -= weight_tab[lvl][pick[lvl]-1];
                end
            end
            for (k = 0; k < n; k++) begin
                res.part     = 4'(k);
                res.supplier = found ? keep[k] : 5'd0;
                res.weight   = 20'(best);
                res.found    = found;
                res.last     = (k + 1 == n);
                expected.push_back(res);
            end
        endfunction

        function void note_item(t_in_item it);
            if (it.operation == OP_LOAD) begin
                weight_tab[it.part_index][it.supplier_index] = it.part_weight;
                price_tab[it.part_index][it.supplier_index]  = it.part_price;
            end else begin
                solve_min_weight();
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_outcome got);
            t_outcome want;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("result for part %0d with none due", got.part));
                return;
            end
            want = expected.pop_front();
            if (got.part != want.part)
                report_mismatch($sformatf("part %0d, due %0d", got.part, want.part));
            if (got.supplier != want.supplier)
                report_mismatch($sformatf("part %0d supplier %0d, due %0d",
                                          want.part, got.supplier, want.supplier));
            if (got.weight != want.weight)
                report_mismatch($sformatf("part %0d weight %0d, due %0d",
                                          want.part, got.weight, want.weight));
            if (got.found != want.found)
                report_mismatch($sformatf("part %0d found %0b, due %0b",
                                          want.part, got.found, want.found));
            if (got.last != want.last)
                report_mismatch($sformatf("part %0d last %0b, due %0b",
                                          want.part, got.last, want.last));
        endtask
    endclass

    // Clock, reset and block-side signals
    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [39:0] s_tdata    = '0;  // part_index, supplier_index, part_weight, part_price
    logic [0:0]  s_tuser    = '0;  // operation
    logic        m_tready   = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;   // out_part, chosen_supplier, best_weight, zero pad
    wire  [0:0]  m_axis_tuser;   // found
    wire         m_axis_tlast;
    wire  [31:0] prdata;
    wire         pready;

    search_scoreboard sb = new();
    bit              loaded [PART_SLOTS][SUPP_SLOTS];
    bit              hold_request;
    int              send_burst;
    int              recv_burst;
    int unsigned     items_sent;

    min_weight_supplier_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle cycles before an item; now and then a run with no gaps at all
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            burst = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Small values for ties, the extremes, or anything at all
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 15));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_item(t_op op, int p, int s, int w, int c);
        t_in_item it;
        it.operation      = op;
        it.part_index     = 4'(p);
        it.supplier_index = 4'(s);
        it.part_weight    = 16'(w);
        it.part_price     = 16'(c);
        return it;
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(t_in_item it);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= {it.part_price, it.part_weight, it.supplier_index, it.part_index};
        s_tuser  <= it.operation;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic load_entry(int p, int s, int w, int c);
        send_item(make_item(OP_LOAD, p, s, w, c));
        loaded[p][s] = 1'b1;
    endtask

    // The search must never read an entry that was never loaded
    task automatic start_search();
        for (int p = 0; p < sb.active_parts(); p++)
            for (int s = 0; s < sb.active_suppliers(); s++)
                if (!loaded[p][s])
                    load_entry(p, s, pick_value(), pick_value());
        send_item(make_item(OP_START, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 65535), $urandom_range(0, 65535)));
    endtask

    // Wait until every result is in and the last load has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic write_config(int parts, int suppliers, logic [20:0] limit);
        drain();
        apb_write(REG_PART_COUNT, 32'(parts));
        apb_write(REG_SUPPLIER_COUNT, 32'(suppliers));
        apb_write(REG_PRICE_LIMIT, 32'(limit));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int       stall;
        t_outcome got;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = draw_gap(recv_burst);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.part     = m_axis_tdata[3:0];
            got.supplier = m_axis_tdata[8:4];
            got.weight   = m_axis_tdata[28:9];
            got.found    = m_axis_tuser[0];
            got.last     = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Stimulus
    initial begin
        int          n_cfg, m_cfg, searches;
        logic [20:0] limit;
        bit          first_phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: single part, single supplier, zero price limit
        load_entry(0, 0, 65535, 65535);
        start_search();
        load_entry(0, 0, 0, 0);
        start_search();

        // Weight tie on part 0, lighter second supplier on part 1
        write_config(2, 2, 21'd100);
        load_entry(0, 1, 0, 0);
        load_entry(1, 0, 9, 50);
        load_entry(1, 1, 4, 60);
        start_search();

        // No supplier at all, then a zero part count, then a zero price limit
        write_config(2, 0, 21'd100);
        start_search();
        write_config(0, 2, 21'd100);
        start_search();
        write_config(2, 2, 21'd0);
        start_search();

        // Sixteen parts, one supplier: totals at and just under the no-solution weight
        write_config(31, 1, LIMIT_MAX);
        for (int p = 0; p < 15; p++)
            load_entry(p, 0, 65535, pick_value());
        load_entry(15, 0, 16974, pick_value());
        start_search();
        load_entry(15, 0, 16973, pick_value());
        start_search();

        // One part, every supplier, many ties
        write_config(1, 31, LIMIT_MAX);
        for (int s = 0; s < 16; s++)
            load_entry(0, s, $urandom_range(0, 3), pick_value());
        start_search();
        write_config(1, 16, 21'($urandom_range(0, 40000)));
        start_search();

        // Sixteen parts, two suppliers: price limit forces deep backtracking
        write_config(16, 2, 21'd12);
        for (int p = 0; p < 16; p++) begin
            load_entry(p, 0, 0, 1);
            load_entry(p, 1, 5, 0);
        end
        start_search();

        // Random phases: loads with random content, then a start.
        // The first phase uses four parts so the held results back up into the input.
        first_phase = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (first_phase)
                n_cfg = 4;
            else
                n_cfg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            m_cfg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            case ($urandom_range(0, 3))
                0:       limit = LIMIT_MAX;
                1:       limit = 21'($urandom_range(0, 64));
                default: limit = 21'($urandom_range(0, 200000));
            endcase
            write_config(n_cfg, m_cfg, limit);
            searches = first_phase ? 3 : $urandom_range(1, 3);
            repeat (searches) begin
                repeat ($urandom_range(0, 4))
                    load_entry($urandom_range(0, sb.active_parts() - 1),
                               (sb.active_suppliers() == 0) ? $urandom_range(0, 15) :
                               $urandom_range(0, sb.active_suppliers() - 1),
                               pick_value(), pick_value());
                // stray loads anywhere in the tables
                repeat ($urandom_range(0, 2))
                    load_entry($urandom_range(0, 15), $urandom_range(0, 15),
                               pick_value(), pick_value());
                if (first_phase) begin
                    hold_request = 1'b1;
                    first_phase  = 1'b0;
                end
                start_search();
            end
        end

        drain();
        repeat (24) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: min_weight_supplier_search.f
+incdir+hdl
hdl/mwss_pkg.sv
hdl/mwss_table.sv
hdl/mwss_search.sv
hdl/min_weight_supplier_search.sv
sim/tb_top.sv
